FILE: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante |=> cons
`define BRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/brf_pkg.sv
package brf_pkg;

  localparam int KIND_W  = 2;
  localparam int LEN_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int OVF_W   = 32;

  localparam logic [KIND_W-1:0] KIND_RESET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WSTART = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WBYTE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_RESP  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

FILE: hdl/brf_ifs.sv
interface brf_in_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::KIND_W-1:0]  kind;
  logic [brf_pkg::LEN_W-1:0]   length;
  logic [brf_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, kind, length, data_byte, input ready);
  modport sink   (input valid, kind, length, data_byte, output ready);
endinterface

interface brf_out_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_valid;
  logic [brf_pkg::LEN_W-1:0]   accepted_count;
  logic                        last;
  logic [brf_pkg::LEN_W-1:0]   fill_level;
  logic [brf_pkg::LEN_W-1:0]   free_space;
  logic [brf_pkg::OVF_W-1:0]   overflow_total;

  modport source (output valid, out_byte, byte_valid, accepted_count, last,
                  fill_level, free_space, overflow_total, input ready);
  modport sink   (input valid, out_byte, byte_valid, accepted_count, last,
                  fill_level, free_space, overflow_total, output ready);
endinterface

FILE: hdl/byte_ring_fifo_chunked.sv
// Circular byte FIFO of RING_BYTES slots, one slot always kept empty.
// in_bus (valid/ready) takes one command beat: reset ring, write start
// (chunk length), write byte, or read request (capacity, clamped to MAX_READ).
// out_bus (valid/ready) returns result beats; every beat carries the fill
// level, free space and overflow count as they stand after the whole command.
// A read that emits N bytes gives N beats, the final one marked last; any
// other command gives exactly one beat with last set.
// Flow: one command at a time. in_ready is high only while idle. A non-read
// command or an empty read passes from idle through the execute state to the
// response state, where its beat is offered. A read of N bytes passes through
// the execute state and then, for each byte, a fetch state that registers a
// read of the byte store and an emit state that presents it.
// A stalled receiver holds the current beat steady; nothing advances and
// no new command is taken until every beat of the command has been taken.
// Reset (rst_n low) clears pointers, fill, chunk and overflow counter; the
// byte store is not cleared and needs no clearing pass, since no read
// reaches an unwritten slot.
module byte_ring_fifo_chunked #(
  parameter int RING_BYTES = 4096,
  parameter int MAX_READ   = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  brf_in_if.sink        in_bus,
  brf_out_if.source     out_bus
);

  localparam int PTR_W = $clog2(RING_BYTES);
  localparam int W     = (PTR_W > brf_pkg::LEN_W) ? PTR_W : brf_pkg::LEN_W;
  localparam int CNT_W = $clog2(MAX_READ + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_BYTES - 1);
  localparam logic [W-1:0]     USABLE   = W'(RING_BYTES - 1);

  brf_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0]            wp_r, wp_nxt;
  logic [PTR_W-1:0]            rp_r, rp_nxt;
  logic [PTR_W-1:0]            fill_r, fill_nxt;
  logic [brf_pkg::LEN_W-1:0]   chunk_r, chunk_nxt;
  logic [brf_pkg::OVF_W-1:0]   ovf_r, ovf_nxt;
  logic [brf_pkg::LEN_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;

  logic [brf_pkg::KIND_W-1:0]  kind_r;
  logic [brf_pkg::LEN_W-1:0]   len_r;
  logic [brf_pkg::BYTE_W-1:0]  data_r;

  logic [brf_pkg::BYTE_W-1:0]  mem [RING_BYTES];
  logic [brf_pkg::BYTE_W-1:0]  mem_q_r;
  logic                        mem_we;

  logic [W-1:0]                fill_w;
  logic [W-1:0]                free_w;
  logic [CNT_W-1:0]            cap;
  logic [CNT_W-1:0]            rd_count;
  logic                        in_fire;
  logic                        out_fire;
  logic                        emit_last;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;

  assign fill_w = W'(fill_r);
  assign free_w = USABLE - fill_w;

  assign cap = (len_r > brf_pkg::LEN_W'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                   : len_r[CNT_W-1:0];
  assign rd_count = (W'(cap) > fill_w) ? fill_w[CNT_W-1:0] : cap;

  assign emit_last = (idx_r == CNT_W'(count_r - 1'b1));

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    fill_nxt  = fill_r;
    chunk_nxt = chunk_r;
    ovf_nxt   = ovf_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    mem_we    = 1'b0;
    case (state_r)
      brf_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = brf_pkg::ST_EXEC;
      end
      brf_pkg::ST_EXEC: begin
        state_nxt = brf_pkg::ST_RESP;
        acc_nxt   = '0;
        case (kind_r)
          brf_pkg::KIND_RESET: begin
            wp_nxt    = '0;
            rp_nxt    = '0;
            fill_nxt  = '0;
            chunk_nxt = '0;
            ovf_nxt   = '0;
          end
          brf_pkg::KIND_WSTART: begin
            if (W'(len_r) > free_w) begin
              ovf_nxt   = ovf_r + 1'b1;
              chunk_nxt = '0;
            end else begin
              chunk_nxt = len_r;
              acc_nxt   = len_r;
            end
          end
          brf_pkg::KIND_WBYTE: begin
            if (chunk_r != '0 && free_w != '0) begin
              mem_we    = 1'b1;
              wp_nxt    = ptr_next(wp_r);
              fill_nxt  = fill_r + 1'b1;
              chunk_nxt = chunk_r - 1'b1;
              acc_nxt   = brf_pkg::LEN_W'(1);
            end
          end
          default: begin
            // read: fill drops by the whole count up front, rp walks per byte
            if (rd_count != '0) begin
              count_nxt = rd_count;
              idx_nxt   = '0;
              fill_nxt  = fill_r - PTR_W'(rd_count);
              state_nxt = brf_pkg::ST_FETCH;
            end
          end
        endcase
      end
      brf_pkg::ST_RESP: begin
        if (out_fire) state_nxt = brf_pkg::ST_IDLE;
      end
      brf_pkg::ST_FETCH: begin
        state_nxt = brf_pkg::ST_EMIT;
      end
      brf_pkg::ST_EMIT: begin
        if (out_fire) begin
          rp_nxt    = ptr_next(rp_r);
          idx_nxt   = idx_r + 1'b1;
          state_nxt = emit_last ? brf_pkg::ST_IDLE : brf_pkg::ST_FETCH;
        end
      end
      default: state_nxt = brf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      fill_r  <= '0;
      chunk_r <= '0;
      ovf_r   <= '0;
      acc_r   <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      fill_r  <= fill_nxt;
      chunk_r <= chunk_nxt;
      ovf_r   <= ovf_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_bus.kind;
      len_r  <= in_bus.length;
      data_r <= in_bus.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wp_r] <= data_r;
    mem_q_r <= mem[rp_r];
  end

  assign in_bus.ready = (state_r == brf_pkg::ST_IDLE);

  assign out_bus.valid          = (state_r == brf_pkg::ST_RESP) ||
                                  (state_r == brf_pkg::ST_EMIT);
  assign out_bus.byte_valid     = (state_r == brf_pkg::ST_EMIT);
  assign out_bus.out_byte       = (state_r == brf_pkg::ST_EMIT) ? mem_q_r : '0;
  assign out_bus.accepted_count = (state_r == brf_pkg::ST_EMIT) ?
                                  brf_pkg::LEN_W'(count_r) : acc_r;
  assign out_bus.last           = (state_r == brf_pkg::ST_EMIT) ? emit_last : 1'b1;
  assign out_bus.fill_level     = fill_w[brf_pkg::LEN_W-1:0];
  assign out_bus.free_space     = free_w[brf_pkg::LEN_W-1:0];
  assign out_bus.overflow_total = ovf_r;

endmodule

FILE: hdl/brf_checker.sv
`include "assert_macros.svh"

module brf_checker #(
  parameter int RING_BYTES = 4096
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brf_pkg::BYTE_W-1:0] out_byte,
  input logic                       byte_valid,
  input logic [brf_pkg::LEN_W-1:0]  accepted_count,
  input logic                       last,
  input logic [brf_pkg::LEN_W-1:0]  fill_level,
  input logic [brf_pkg::LEN_W-1:0]  free_space
);

  // one command in flight: no new beat taken while a result is pending
  `BRF_ASSERT_IMP(a_busy_while_result, clk, rst_n, out_valid, !in_ready, "input ready during result")

  `BRF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after accept")

  `BRF_ASSERT_IMP(a_level_sum, clk, rst_n, out_valid, brf_pkg::LEN_W'(fill_level + free_space) == brf_pkg::LEN_W'(RING_BYTES - 1), "fill plus free mismatch")

  // non-byte results are single beats with a zero byte field
  `BRF_ASSERT_IMP(a_single_beat, clk, rst_n, out_valid && !byte_valid, last && out_byte == '0, "bad non-byte beat")

  `BRF_ASSERT_NXT(a_hold_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(accepted_count) && $stable(last), "beat changed under stall")

endmodule

bind byte_ring_fifo_chunked brf_checker #(.RING_BYTES(RING_BYTES)) u_brf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_byte       (out_bus.out_byte),
  .byte_valid     (out_bus.byte_valid),
  .accepted_count (out_bus.accepted_count),
  .last           (out_bus.last),
  .fill_level     (out_bus.fill_level),
  .free_space     (out_bus.free_space)
);
